FILE: src/pes_pkg.sv
package pes_pkg;

   // Default size of the ready store.
   localparam int SLOTS_DEFAULT = 32;

   // Field widths. A position covers slot indexes and the fill count up to 511.
   localparam int POS_W   = 9;
   localparam int ID_W    = 10;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 32;
   localparam int BURST_W = 16;
   localparam int KIND_W  = 3;

   // Input function codes.
   localparam logic FUNC_ARRIVAL = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // Policy register codes.
   localparam logic POLICY_FIXED = 1'b0;
   localparam logic POLICY_EDF   = 1'b1;

   // Result kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_ADMIT  = 3'd0,
      KIND_REJECT = 3'd1,
      KIND_IDLE   = 3'd2,
      KIND_RAN    = 3'd3,
      KIND_DONE   = 3'd4
   } kind_type;

   // One task as held in a cell.
   typedef struct packed {
      logic               valid;
      logic               started;
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [TIME_W-1:0]  deadline;
      logic [BURST_W-1:0] remaining;
      logic [TIME_W-1:0]  arrival;
      logic [TIME_W-1:0]  start;
   } slot_type;

   // Best task seen so far on its way down the chain, with its position.
   typedef struct packed {
      slot_type         slot;
      logic [POS_W-1:0] pos;
   } cand_type;

   // Update broadcast from the controller to every cell.
   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_RUN  = 2'd2,
      CMD_POP  = 2'd3
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [POS_W-1:0]  pos;
      logic [TIME_W-1:0] now;
      slot_type          data;
   } cmd_type;

endpackage

FILE: src/pes_cell.sv
module pes_cell #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               policy_mode,
   input  pes_pkg::cmd_type   cmd,
   input  pes_pkg::slot_type  right_slot,
   output pes_pkg::slot_type  slot,
   input  pes_pkg::cand_type  cand_in,
   output pes_pkg::cand_type  cand_out
);

   localparam logic [pes_pkg::POS_W-1:0] MY_POS = pes_pkg::POS_W'(INDEX);

   logic              valid_ff, valid_in;
   logic              started_ff, started_in;
   pes_pkg::slot_type data_ff, data_in;
   pes_pkg::cand_type cand_ff, cand_in_next;
   logic              hit;
   logic              shift;
   logic              mine_better;
   logic              take;

   // Stored task as seen by the neighbors and the selection logic.
   always_comb begin
      slot         = data_ff;
      slot.valid   = valid_ff;
      slot.started = started_ff;
   end

   assign hit   = (cmd.pos == MY_POS);
   assign shift = (cmd.pos <= MY_POS);

   // Apply the broadcast update to this cell.
   always_comb begin
      valid_in   = valid_ff;
      started_in = started_ff;
      data_in    = data_ff;
      case (cmd.op)
         pes_pkg::CMD_PUSH: begin
            if (hit) begin
               valid_in   = 1'b1;
               started_in = 1'b0;
               data_in    = cmd.data;
            end
         end
         pes_pkg::CMD_RUN: begin
            if (hit) begin
               data_in.remaining = data_ff.remaining - 1'b1;
               if (!started_ff) begin
                  started_in   = 1'b1;
                  data_in.start = cmd.now;
               end
            end
         end
         pes_pkg::CMD_POP: begin
            // Cells at and after the finished task close the gap.
            if (shift) begin
               valid_in   = right_slot.valid;
               started_in = right_slot.started;
               data_in    = right_slot;
            end
         end
         default: begin
         end
      endcase
   end

   // Replace the incoming candidate only when this task is strictly better,
   // so the earliest admitted task wins a tie.
   always_comb begin
      if (policy_mode == pes_pkg::POLICY_EDF) begin
         mine_better = (data_ff.deadline < cand_in.slot.deadline);
      end else begin
         mine_better = (data_ff.prio > cand_in.slot.prio);
      end
      take = valid_ff && (!cand_in.slot.valid || mine_better);
      if (take) begin
         cand_in_next.slot = slot;
         cand_in_next.pos  = MY_POS;
      end else begin
         cand_in_next = cand_in;
      end
   end

   assign cand_out = cand_ff;

   // Control bits of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         cand_ff    <= '0;
      end else begin
         valid_ff   <= valid_in;
         started_ff <= started_in;
         cand_ff    <= cand_in_next;
      end
   end

   // Task payload.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: src/preemptive_priority_edf_scheduler.sv
// Arrival: the result is registered as the request is accepted.
// Tick with an empty store: handled like an arrival, with the result registered directly.
// Tick with tasks: the block scans while the selection wave crosses all SLOTS cells,
// and takes no new request until the result is registered.
// Synchronous reset empties the store, clears the clock and selects fixed priority.
module preemptive_priority_edf_scheduler #(
   parameter int SLOTS = pes_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [pes_pkg::ID_W-1:0]      req_task_id,
   input  logic [pes_pkg::PRIO_W-1:0]    req_task_priority,
   input  logic [pes_pkg::TIME_W-1:0]    req_task_deadline,
   input  logic [pes_pkg::BURST_W-1:0]   req_task_burst,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pes_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [pes_pkg::ID_W-1:0]      rsp_out_task_id,
   output logic [pes_pkg::TIME_W-1:0]    rsp_tick_time,
   output logic                          rsp_missed,
   output logic [pes_pkg::TIME_W-1:0]    rsp_wait_time,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_policy_mode
);

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);
   localparam logic [pes_pkg::TIME_W-1:0] TIME_MAX = {pes_pkg::TIME_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic [pes_pkg::TIME_W-1:0]   clock_ff, clock_in;
   logic [pes_pkg::TIME_W-1:0]   clock_next;
   logic                         policy_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   pes_pkg::kind_type            rsp_kind_ff, rsp_kind_in;
   logic [pes_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [pes_pkg::TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic                         rsp_missed_ff, rsp_missed_in;
   logic [pes_pkg::TIME_W-1:0]   rsp_wait_ff, rsp_wait_in;
   logic                         rsp_load;
   logic                         rsp_free;
   logic                         accept;
   logic                         scan_done;
   logic [pes_pkg::TIME_W-1:0]   eff_start;
   pes_pkg::cmd_type             cmd;
   pes_pkg::slot_type            slot_chain [SLOTS];
   pes_pkg::cand_type            cand_chain [SLOTS+1];
   pes_pkg::cand_type            winner;
   logic [SLOTS-1:0]             valid_vec;

   // Handshakes.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign scan_done = (state_ff == ST_SCAN) && (scan_ff == CNT_FULL) && rsp_free;

   // The clock saturates at its maximum.
   assign clock_next = (clock_ff == TIME_MAX) ? clock_ff : clock_ff + 1'b1;

   // Chain of cells; the winner leaves the last cell.
   assign cand_chain[0] = '0;
   assign winner        = cand_chain[SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      pes_pkg::slot_type right;
      if (i == SLOTS - 1) begin : g_last
         assign right = '0;
      end else begin : g_inner
         assign right = slot_chain[i+1];
      end
      assign valid_vec[i] = slot_chain[i].valid;
      pes_cell #(
         .INDEX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .policy_mode (policy_ff),
         .cmd         (cmd),
         .right_slot  (right),
         .slot        (slot_chain[i]),
         .cand_in     (cand_chain[i]),
         .cand_out    (cand_chain[i+1])
      );
   end

   // Start time as the run will record it.
   assign eff_start = winner.slot.started ? winner.slot.start : clock_ff;

   // Controller: sequencing, cell updates and the result of each transaction.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      clock_in      = clock_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = pes_pkg::KIND_IDLE;
      rsp_id_in     = '0;
      rsp_time_in   = clock_ff;
      rsp_missed_in = 1'b0;
      rsp_wait_in   = '0;

      cmd                = '0;
      cmd.op             = pes_pkg::CMD_NONE;
      cmd.now            = clock_ff;
      cmd.data.valid     = 1'b1;
      cmd.data.started   = 1'b0;
      cmd.data.id        = req_task_id;
      cmd.data.prio      = req_task_priority;
      cmd.data.deadline  = req_task_deadline;
      cmd.data.remaining = req_task_burst;
      cmd.data.arrival   = clock_ff;
      cmd.data.start     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               if (req_func == pes_pkg::FUNC_ARRIVAL) begin
                  // Ids are ten bits wide and already below the id range.
                  rsp_id_in = req_task_id;
                  if (count_ff == CNT_FULL) begin
                     rsp_kind_in = pes_pkg::KIND_REJECT;
                  end else begin
                     rsp_kind_in = pes_pkg::KIND_ADMIT;
                     cmd.op      = pes_pkg::CMD_PUSH;
                     cmd.pos     = pes_pkg::POS_W'(count_ff);
                     count_in    = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_kind_in = pes_pkg::KIND_IDLE;
                  rsp_time_in = clock_next;
                  clock_in    = clock_next;
               end else begin
                  rsp_load = 1'b0;
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff != CNT_FULL) begin
               scan_in = scan_ff + 1'b1;
            end
            if (scan_done) begin
               rsp_load    = 1'b1;
               rsp_id_in   = winner.slot.id;
               rsp_time_in = clock_next;
               clock_in    = clock_next;
               cmd.pos     = winner.pos;
               state_in    = ST_IDLE;
               if (winner.slot.remaining <= pes_pkg::BURST_W'(1)) begin
                  // Last unit: report and close the gap in the chain.
                  cmd.op        = pes_pkg::CMD_POP;
                  count_in      = count_ff - 1'b1;
                  rsp_kind_in   = pes_pkg::KIND_DONE;
                  rsp_missed_in = (clock_next > winner.slot.deadline);
                  rsp_wait_in   = (eff_start > winner.slot.arrival) ?
                                  eff_start - winner.slot.arrival : '0;
               end else begin
                  cmd.op      = pes_pkg::CMD_RUN;
                  rsp_kind_in = pes_pkg::KIND_RAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         clock_ff     <= '0;
         policy_ff    <= pes_pkg::POLICY_FIXED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_policy_mode;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_missed_ff <= rsp_missed_in;
         rsp_wait_ff   <= rsp_wait_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_task_id = rsp_id_ff;
   assign rsp_tick_time   = rsp_time_ff;
   assign rsp_missed      = rsp_missed_ff;
   assign rsp_wait_time   = rsp_wait_ff;

   // The selection wave always finds a task when the store is not empty.
   a_winner_found: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> winner.slot.valid)
      else $error("scan finished without a winner");

   // The fill count matches the occupied cells.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("fill count differs from occupied cells");

   // The fill count never passes the store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fill count beyond store size");

   // An admitted arrival grows the store by one.
   a_admit_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == pes_pkg::FUNC_ARRIVAL && count_ff != CNT_FULL)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("admission did not grow the store");

   // The tick clock never goes backwards.
   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> clock_ff >= $past(clock_ff))
      else $error("clock went backwards");

endmodule

FILE: tb/sv/preemptive_priority_edf_scheduler_tb.sv
`timescale 1ns / 100ps

module preemptive_priority_edf_scheduler_tb;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int STORE_DEPTH   = pes_pkg::SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 100;
   localparam int MIX_WINDOW    = 40;
   localparam int RANDOM_ITEMS  = PHASES * PHASE_ITEMS;
   localparam int LONG_JOB_A    = RANDOM_ITEMS - 60;
   localparam int LONG_JOB_B    = RANDOM_ITEMS - 30;
   localparam int DIRECTED_ROWS = 22;
   localparam logic [pes_pkg::TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

   // Short names for the codes used in the directed table.
   localparam logic ARRIVE = pes_pkg::FUNC_ARRIVAL;
   localparam logic TICK   = pes_pkg::FUNC_TICK;
   localparam logic FIXED  = pes_pkg::POLICY_FIXED;
   localparam logic EDF    = pes_pkg::POLICY_EDF;

   // One request as it travels on the input channel.
   typedef struct packed {
      logic                        func;
      logic [pes_pkg::ID_W-1:0]    id;
      logic [pes_pkg::PRIO_W-1:0]  prio;
      logic [pes_pkg::TIME_W-1:0]  deadline;
      logic [pes_pkg::BURST_W-1:0] burst;
   } request_type;

   // One response as it travels on the result channel.
   typedef struct packed {
      pes_pkg::kind_type           kind;
      logic [pes_pkg::ID_W-1:0]    id;
      logic [pes_pkg::TIME_W-1:0]  tick_time;
      logic                        missed;
      logic [pes_pkg::TIME_W-1:0]  wait_time;
   } outcome_type;

   // A ready job as the scheduler model keeps it.
   typedef struct packed {
      logic [pes_pkg::ID_W-1:0]    id;
      logic [pes_pkg::PRIO_W-1:0]  prio;
      logic [pes_pkg::TIME_W-1:0]  deadline;
      logic [pes_pkg::BURST_W-1:0] remaining;
      logic [pes_pkg::TIME_W-1:0]  arrival;
      logic [pes_pkg::TIME_W-1:0]  first_run;
      logic                        started;
   } job_entry_type;

   // One row of the directed table; the response is typed in only where marked.
   typedef struct {
      logic        policy;
      request_type item;
      logic        typed;
      outcome_type want;
   } dir_row_type;

   localparam outcome_type NO_OUTCOME = '{pes_pkg::KIND_ADMIT, '0, '0, 1'b0, '0};

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_func = 1'b0;
   logic [pes_pkg::ID_W-1:0]     req_task_id = '0;
   logic [pes_pkg::PRIO_W-1:0]   req_task_priority = '0;
   logic [pes_pkg::TIME_W-1:0]   req_task_deadline = '0;
   logic [pes_pkg::BURST_W-1:0]  req_task_burst = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [pes_pkg::KIND_W-1:0]   rsp_result_kind;
   logic [pes_pkg::ID_W-1:0]     rsp_out_task_id;
   logic [pes_pkg::TIME_W-1:0]   rsp_tick_time;
   logic                         rsp_missed;
   logic [pes_pkg::TIME_W-1:0]   rsp_wait_time;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic                         csr_policy_mode = 1'b0;

   // Scheduler model state.
   logic                         policy_sel = pes_pkg::POLICY_FIXED;
   logic [pes_pkg::TIME_W-1:0]   sched_now = '0;
   job_entry_type                ready_jobs[$];
   outcome_type                  pending_outcomes[$];
   outcome_type                  oldest_outcome;

   int                           error_count = 0;
   int                           policy_writes = 0;
   int                           missed_count = 0;
   int                           kind_tally[8];
   int                           cycle_count = 0;
   int                           stall_timer = 0;
   logic                         calm_phase = 1'b0;
   dir_row_type                  directed_rows[DIRECTED_ROWS];

   preemptive_priority_edf_scheduler u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_task_deadline (req_task_deadline),
      .req_task_burst    (req_task_burst),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_task_id   (rsp_out_task_id),
      .rsp_tick_time     (rsp_tick_time),
      .rsp_missed        (rsp_missed),
      .rsp_wait_time     (rsp_wait_time),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_policy_mode   (csr_policy_mode)
   );

   always #CLOCK_HALF clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Back-pressure on the result channel: mostly short stalls, a few long ones.
   always @(posedge clock) begin
      if (reset || calm_phase) begin
         rsp_stall   <= 1'b0;
         stall_timer <= 0;
      end else if (stall_timer > 0) begin
         stall_timer <= stall_timer - 1;
      end else begin
         rsp_stall <= !rsp_stall;
         if (rsp_stall) begin
            stall_timer <= ($urandom_range(3) == 0) ? $urandom_range(10, 80)
                                                    : $urandom_range(0, 6);
         end else begin
            stall_timer <= ($urandom_range(9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
         end
      end
   end

   // Compare every accepted response with the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("Response with no transaction pending: kind %0d id %0d",
                   rsp_result_kind, rsp_out_task_id);
            error_count++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            kind_tally[rsp_result_kind]++;
            if (rsp_result_kind == pes_pkg::KIND_DONE && rsp_missed)
               missed_count++;
            if (rsp_result_kind !== oldest_outcome.kind) begin
               $error("result_kind: expected %0d, got %0d", oldest_outcome.kind,
                      rsp_result_kind);
               error_count++;
            end
            if (rsp_out_task_id !== oldest_outcome.id) begin
               $error("out_task_id: expected %0d, got %0d", oldest_outcome.id,
                      rsp_out_task_id);
               error_count++;
            end
            if (rsp_tick_time !== oldest_outcome.tick_time) begin
               $error("tick_time: expected %0d, got %0d", oldest_outcome.tick_time,
                      rsp_tick_time);
               error_count++;
            end
            if (rsp_missed !== oldest_outcome.missed) begin
               $error("missed: expected %0d, got %0d", oldest_outcome.missed, rsp_missed);
               error_count++;
            end
            if (rsp_wait_time !== oldest_outcome.wait_time) begin
               $error("wait_time: expected %0d, got %0d", oldest_outcome.wait_time,
                      rsp_wait_time);
               error_count++;
            end
         end
      end
   end

   // Scheduler model: applies one request and returns the response it causes.
   function automatic outcome_type schedule_step(input request_type r);
      outcome_type   o;
      job_entry_type cur;
      int            best;
      int            i;
      o = '{pes_pkg::KIND_IDLE, '0, '0, 1'b0, '0};
      cur = '0;
      best = 0;
      if (r.func == pes_pkg::FUNC_ARRIVAL) begin
         o.id = r.id;
         o.tick_time = sched_now;
         if (ready_jobs.size() >= STORE_DEPTH) begin
            o.kind = pes_pkg::KIND_REJECT;
         end else begin
            cur = '{r.id, r.prio, r.deadline, r.burst, sched_now, '0, 1'b0};
            ready_jobs.insert(ready_jobs.size(), cur);
            o.kind = pes_pkg::KIND_ADMIT;
         end
      end else begin
         if (ready_jobs.size() != 0) begin
            // Strictly better wins, so ties stay with the earliest admitted job.
            for (i = 1; i < ready_jobs.size(); i++) begin
               if (policy_sel == pes_pkg::POLICY_EDF) begin
                  if (ready_jobs[i].deadline < ready_jobs[best].deadline)
                     best = i;
               end else if (ready_jobs[i].prio > ready_jobs[best].prio) begin
                  best = i;
               end
            end
            cur = ready_jobs[best];
            o.id = cur.id;
            if (!cur.started) begin
               cur.started = 1'b1;
               cur.first_run = sched_now;
            end
            if (cur.remaining <= 1) begin
               o.kind = pes_pkg::KIND_DONE;
            end else begin
               cur.remaining = cur.remaining - 1'b1;
               o.kind = pes_pkg::KIND_RAN;
            end
            ready_jobs[best] = cur;
         end
         // The clock sticks at its maximum instead of wrapping.
         if (sched_now != TIME_MAX)
            sched_now = sched_now + 1'b1;
         o.tick_time = sched_now;
         if (o.kind == pes_pkg::KIND_DONE) begin
            o.missed = (sched_now > cur.deadline);
            o.wait_time = (cur.first_run > cur.arrival) ? cur.first_run - cur.arrival : '0;
            ready_jobs.delete(best);
         end
      end
      return o;
   endfunction

   // Drive one transaction after a random gap and record its expected response.
   task automatic send_request(input request_type r, input logic typed,
                               input outcome_type want);
      int          gap;
      outcome_type predicted;
      if (calm_phase)
         gap = 0;
      else if ($urandom_range(9) < 6)
         gap = 0;
      else if ($urandom_range(3) != 0)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(5, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= r.func;
      req_task_id       <= r.id;
      req_task_priority <= r.prio;
      req_task_deadline <= r.deadline;
      req_task_burst    <= r.burst;
      do @(posedge clock); while (req_stall);
      predicted = schedule_step(r);
      pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
   endtask

   // Stop sending and wait until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // Policy register write; only called while the block is idle.
   task automatic write_policy(input logic mode);
      csr_valid       <= 1'b1;
      csr_policy_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      policy_sel = mode;
      policy_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          idx;
      int          phase;
      int          k;
      int          n;
      int          tick_pct;
      logic        mode;
      request_type item;

      foreach (kind_tally[j]) kind_tally[j] = 0;
      tick_pct = 50;

      // Directed cases: empty tick, field extremes, priority ties, zero burst,
      // missed deadlines, then EDF ordering, ties on deadline and preemption.
      directed_rows = '{
         '{FIXED, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_IDLE, 10'd0, 32'd1, 1'b0, 32'd0}},
         '{FIXED, '{ARRIVE, 10'd1023, 8'd255, TIME_MAX, 16'd2}, 1'b1,
           '{pes_pkg::KIND_ADMIT, 10'd1023, 32'd1, 1'b0, 32'd0}},
         '{FIXED, '{ARRIVE, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_ADMIT, 10'd0, 32'd1, 1'b0, 32'd0}},
         '{FIXED, '{ARRIVE, 10'd5, 8'd255, 32'd3, 16'd1}, 1'b1,
           '{pes_pkg::KIND_ADMIT, 10'd5, 32'd1, 1'b0, 32'd0}},
         '{FIXED, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_RAN, 10'd1023, 32'd2, 1'b0, 32'd0}},
         '{FIXED, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_DONE, 10'd1023, 32'd3, 1'b0, 32'd0}},
         '{FIXED, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_DONE, 10'd5, 32'd4, 1'b1, 32'd2}},
         '{FIXED, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_DONE, 10'd0, 32'd5, 1'b1, 32'd3}},
         '{FIXED, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b1,
           '{pes_pkg::KIND_IDLE, 10'd0, 32'd6, 1'b0, 32'd0}},
         '{EDF, '{ARRIVE, 10'd7, 8'd0, TIME_MAX, 16'd1}, 1'b0, NO_OUTCOME},
         '{EDF, '{ARRIVE, 10'd8, 8'd255, 32'd100, 16'd1}, 1'b0, NO_OUTCOME},
         '{EDF, '{ARRIVE, 10'd9, 8'd10, 32'd100, 16'd1}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd1023, 8'd255, TIME_MAX, 16'hFFFF}, 1'b0, NO_OUTCOME},
         '{EDF, '{ARRIVE, 10'd20, 8'd0, 32'd50, 16'd3}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME},
         '{EDF, '{ARRIVE, 10'd21, 8'd0, 32'd20, 16'd1}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME},
         '{EDF, '{TICK, 10'd0, 8'd0, 32'd0, 16'd0}, 1'b0, NO_OUTCOME}
      };

      // Synchronous reset, held at the start and then released.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table, switching policy only when the block is idle.
      for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
         if (directed_rows[idx].policy != policy_sel) begin
            settle();
            write_policy(directed_rows[idx].policy);
         end
         send_request(directed_rows[idx].item, directed_rows[idx].typed,
                      directed_rows[idx].want);
      end

      // Random phases, each under one policy; some phases run without idling.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            mode = pes_pkg::POLICY_FIXED;
         else if (phase == 1)
            mode = pes_pkg::POLICY_EDF;
         else
            mode = logic'($urandom_range(1));
         settle();
         calm_phase = (phase % 4 == 3);
         write_policy(mode);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            n = phase * PHASE_ITEMS + k;
            // Every MIX_WINDOW items, pick at random between filling the store, draining it and a balanced mix.
            if (k % MIX_WINDOW == 0) begin
               case ($urandom_range(2))
                  0: tick_pct = 10;
                  1: tick_pct = 45;
                  default: tick_pct = 85;
               endcase
            end
            if (n == LONG_JOB_A || n == LONG_JOB_B) begin
               // Very long jobs with the lowest priority and the latest deadline; they stay until the end.
               item = '{ARRIVE, pes_pkg::ID_W'($urandom), 8'd0, TIME_MAX,
                        (n == LONG_JOB_A) ? 16'hFFFF
                                          : pes_pkg::BURST_W'($urandom_range(32768, 65535))};
            end else if ($urandom_range(99) < tick_pct) begin
               item = '{TICK, pes_pkg::ID_W'($urandom), pes_pkg::PRIO_W'($urandom),
                        $urandom, pes_pkg::BURST_W'($urandom)};
            end else if ($urandom_range(9) == 0) begin
               item = '{ARRIVE, pes_pkg::ID_W'($urandom), pes_pkg::PRIO_W'($urandom),
                        $urandom, pes_pkg::BURST_W'($urandom_range(0, 8))};
            end else begin
               item = '{ARRIVE, pes_pkg::ID_W'($urandom),
                        pes_pkg::PRIO_W'($urandom_range(1, 255)),
                        sched_now + $urandom_range(0, 60),
                        ($urandom_range(19) == 0) ? pes_pkg::BURST_W'($urandom_range(0, 12))
                                                  : pes_pkg::BURST_W'($urandom_range(1, 5))};
            end
            send_request(item, 1'b0, NO_OUTCOME);
         end
      end

      // Drain, then give any stray response time to show up.
      settle();
      repeat (STORE_DEPTH + 4) @(posedge clock);

      $display("Run covered %0d admitted, %0d rejected, %0d idle, %0d ran, %0d completed",
               kind_tally[pes_pkg::KIND_ADMIT], kind_tally[pes_pkg::KIND_REJECT],
               kind_tally[pes_pkg::KIND_IDLE], kind_tally[pes_pkg::KIND_RAN],
               kind_tally[pes_pkg::KIND_DONE]);
      $display("Policy register written %0d times; %0d completions missed their deadline",
               policy_writes, missed_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
